// ===== rtl/mau_pkg.sv =====
// shared types and constants for the modular arithmetic unit
package mau_pkg;

  localparam int CMD_W = 4;
  localparam int EXP_W = 63;
  localparam int RAW_W = 64;

  localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
  localparam logic [CMD_W-1:0] CMD_POW = 4'd4;
  localparam logic [CMD_W-1:0] CMD_NEG = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RED = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INC = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEC = 4'd8;
  localparam logic [CMD_W-1:0] CMD_EQ  = 4'd9;

  // datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch item, start reducing a, b, raw
    OP_REDSTEP,  // one bit of the restoring reductions
    OP_SIMPLE,   // add/sub/neg/inc/dec/eq/reduce result into acc
    OP_PINIT,    // prepare power or product: prod, base, exponent
    OP_MSTART_P, // start multiply prod*base
    OP_MSTART_S, // start multiply base*base
    OP_MSTART_F, // start final multiply a*prod
    OP_MSTEP,    // one step of double-and-add
    OP_MEND_P,   // write multiply result to prod
    OP_MEND_S,   // write multiply result to base, shift exponent
    OP_MEND_F,   // write multiply result to acc
    OP_ZERO      // acc = 0
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic       red_done;
    logic       mul_done;
    logic       exp_zero;
    logic       exp_lsb;
    logic       mod_small;
    logic [3:0] cmd;
  } sts_t;

endpackage

// ===== rtl/modular_arithmetic_unit.sv =====
// Add, sub, neg, reduce, inc, dec, eq and unused codes go from reduction straight to the
// result; mul adds one final multiply; div and pow first run a multiply loop over the
// exponent bits, then the final multiply. A modulus below two gives a zero result.
// One item at a time; the next item is taken the cycle after the result is loaded, so a
// waiting result does not block it.
// Reset (rst_n, synchronous, active low) clears control and sets modulus to 1000000007.
module modular_arithmetic_unit #(
  parameter int RESIDUE_WIDTH = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [RESIDUE_WIDTH-1:0]      cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // operand_a, operand_b, exponent, raw_value from bit 0 up, zero padded
  input  logic [((2*RESIDUE_WIDTH+127+7)/8)*8-1:0] in_tdata,
  // command
  input  logic [mau_pkg::CMD_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // result, zero padded
  output logic [((RESIDUE_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int RW = RESIDUE_WIDTH;
  localparam int OW = ((RW + 7) / 8) * 8;

  logic [RW-1:0] mod_r, acc, res_r;
  logic          ovalid_r, in_fire, res_load, res_free;
  mau_pkg::ctl_t ctl;
  mau_pkg::sts_t sts;

  // modulus register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= RW'(64'd1000000007);
    else if (cfg_valid) mod_r <= cfg_data;
  end

  assign in_fire  = in_tvalid && in_tready;
  assign res_free = !ovalid_r || out_tready;

  mau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(in_tready),
    .res_load(res_load), .res_free(res_free), .sts(sts), .ctl(ctl)
  );

  mau_datapath #(.RW(RW)) u_dp (
    .clk(clk), .ctl(ctl), .sts(sts), .modulus(mod_r),
    .in_cmd(in_tuser),
    .in_a(in_tdata[RW-1:0]),
    .in_b(in_tdata[2*RW-1:RW]),
    .in_exp(in_tdata[2*RW+62:2*RW]),
    .in_raw(in_tdata[2*RW+126:2*RW+63]),
    .acc(acc)
  );

  // output register transfer
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (res_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) res_r <= acc;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OW'(res_r);

endmodule

// ===== rtl/mau_datapath.sv =====
// datapath: operand reduction, modular adder and shared double-and-add multiplier
module mau_datapath #(
  parameter int RW = 31
) (
  input  logic                       clk,
  input  mau_pkg::ctl_t              ctl,
  output mau_pkg::sts_t              sts,
  input  logic [RW-1:0]              modulus,
  input  logic [mau_pkg::CMD_W-1:0]  in_cmd,
  input  logic [RW-1:0]              in_a,
  input  logic [RW-1:0]              in_b,
  input  logic [mau_pkg::EXP_W-1:0]  in_exp,
  input  logic [mau_pkg::RAW_W-1:0]  in_raw,
  output logic [RW-1:0]              acc
);

  localparam int RAW_W = mau_pkg::RAW_W;
  localparam int CW = $clog2(RAW_W + 1);
  localparam int MW = $clog2(RW + 1);

  logic [mau_pkg::CMD_W-1:0] cmd_r;
  logic [RW-1:0] a_r, b_r, acc_r, prod_r, base_r, mx_r, my_r, mr_r, m_r;
  logic [RW-1:0] ar_r, br_r, rr_r;
  logic [RAW_W-1:0] raw_r;
  logic neg_r;
  logic [mau_pkg::EXP_W-1:0] exp_r;
  logic [CW-1:0] rcnt_r;
  logic [MW-1:0] mcnt_r;
  logic          div_r;

  // restoring remainder step for one shifted-in bit, remainder below m
  function automatic logic [RW-1:0] rstep(input logic [RW-1:0] r, input logic bit_in,
                                          input logic [RW-1:0] m);
    logic [RW:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[RW-1:0];
  endfunction

  function automatic logic [RW-1:0] addm(input logic [RW-1:0] x, input logic [RW-1:0] y,
                                         input logic [RW-1:0] m);
    logic [RW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[RW-1:0];
  endfunction

  function automatic logic [RW-1:0] subm(input logic [RW-1:0] x, input logic [RW-1:0] y,
                                         input logic [RW-1:0] m);
    logic [RW:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    return s[RW-1:0];
  endfunction

  logic [RW-1:0] one_w, dbl_w, mstep_w, simple_w, redres_w;
  logic [RAW_W-1:0] rawabs_w;

  always_comb begin
    one_w = RW'(1);
    dbl_w = addm(mr_r, mr_r, m_r);
    mstep_w = my_r[RW-1] ? addm(dbl_w, mx_r, m_r) : dbl_w;
    redres_w = (neg_r && (rr_r != '0)) ? (m_r - rr_r) : rr_r;
    rawabs_w = in_raw[RAW_W-1] ? (RAW_W'(0) - in_raw) : in_raw;
    simple_w = '0;
    unique case (cmd_r)
      mau_pkg::CMD_ADD: simple_w = addm(ar_r, br_r, m_r);
      mau_pkg::CMD_SUB: simple_w = subm(ar_r, br_r, m_r);
      mau_pkg::CMD_NEG: simple_w = subm('0, ar_r, m_r);
      mau_pkg::CMD_RED: simple_w = redres_w;
      mau_pkg::CMD_INC: simple_w = addm(ar_r, one_w, m_r);
      mau_pkg::CMD_DEC: simple_w = subm(ar_r, one_w, m_r);
      mau_pkg::CMD_EQ:  simple_w = (ar_r == br_r) ? one_w : '0;
      default:          simple_w = '0;
    endcase
  end

  // one register update per controller command
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      mau_pkg::OP_LOAD: begin
        cmd_r  <= in_cmd;
        m_r    <= modulus;
        a_r    <= in_a;
        b_r    <= in_b;
        exp_r  <= in_exp;
        raw_r  <= rawabs_w;
        neg_r  <= in_raw[RAW_W-1];
        ar_r   <= '0;
        br_r   <= '0;
        rr_r   <= '0;
        rcnt_r <= '0;
      end
      mau_pkg::OP_REDSTEP: begin
        if (rcnt_r < CW'(RW)) begin
          ar_r <= rstep(ar_r, a_r[RW-1], m_r);
          br_r <= rstep(br_r, b_r[RW-1], m_r);
          a_r  <= a_r << 1;
          b_r  <= b_r << 1;
        end
        rr_r   <= rstep(rr_r, raw_r[RAW_W-1], m_r);
        raw_r  <= raw_r << 1;
        rcnt_r <= rcnt_r + CW'(1);
      end
      mau_pkg::OP_SIMPLE: acc_r <= simple_w;
      // product keeps b in prod so the final multiply forms a*b
      mau_pkg::OP_PINIT: begin
        prod_r <= (cmd_r == mau_pkg::CMD_MUL) ? br_r : one_w;
        div_r  <= (cmd_r == mau_pkg::CMD_DIV) || (cmd_r == mau_pkg::CMD_MUL);
        if (cmd_r == mau_pkg::CMD_DIV) begin
          base_r <= br_r;
          exp_r  <= {{(mau_pkg::EXP_W-RW){1'b0}}, m_r - RW'(2)};
        end else begin
          base_r <= ar_r;
        end
      end
      mau_pkg::OP_MSTART_P: begin
        mx_r <= prod_r; my_r <= base_r; mr_r <= '0; mcnt_r <= '0;
      end
      mau_pkg::OP_MSTART_S: begin
        mx_r <= base_r; my_r <= base_r; mr_r <= '0; mcnt_r <= '0;
      end
      mau_pkg::OP_MSTART_F: begin
        mx_r <= div_r ? ar_r : prod_r;
        my_r <= div_r ? prod_r : one_w;
        mr_r <= '0; mcnt_r <= '0;
      end
      mau_pkg::OP_MSTEP: begin
        mr_r   <= mstep_w;
        my_r   <= my_r << 1;
        mcnt_r <= mcnt_r + MW'(1);
      end
      mau_pkg::OP_MEND_P: prod_r <= mr_r;
      mau_pkg::OP_MEND_S: begin
        base_r <= mr_r;
        exp_r  <= exp_r >> 1;
      end
      mau_pkg::OP_MEND_F: acc_r <= mr_r;
      mau_pkg::OP_ZERO:   acc_r <= '0;
      default: ;
    endcase
  end

  assign acc           = acc_r;
  assign sts.red_done  = (rcnt_r == CW'(RAW_W));
  assign sts.mul_done  = (mcnt_r == MW'(RW));
  assign sts.exp_zero  = (exp_r == '0);
  assign sts.exp_lsb   = exp_r[0];
  assign sts.mod_small = (modulus < RW'(2));
  assign sts.cmd       = cmd_r;

endmodule

// ===== rtl/mau_ctrl.sv =====
// controller state machine sequencing reduction, multiplies and result transfer
module mau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  output logic           in_ready,
  output logic           res_load,
  input  logic           res_free,
  input  mau_pkg::sts_t  sts,
  output mau_pkg::ctl_t  ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_PLOOP  = 4'd3;
  localparam logic [3:0] S_MULP   = 4'd4;
  localparam logic [3:0] S_ENDP   = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_MULS   = 4'd7;
  localparam logic [3:0] S_ENDS   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_MULF   = 4'd10;
  localparam logic [3:0] S_ENDF   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       small_r, small_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    small_nxt = small_r;
    ctl.op    = mau_pkg::OP_NONE;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctl.op    = mau_pkg::OP_LOAD;
          small_nxt = sts.mod_small;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (small_r) begin
          ctl.op = mau_pkg::OP_ZERO; state_nxt = S_DONE;
        end else if (sts.red_done) begin
          state_nxt = S_DISP;
        end else begin
          ctl.op = mau_pkg::OP_REDSTEP;
        end
      end
      S_DISP: begin
        if (sts.cmd == mau_pkg::CMD_MUL || sts.cmd == mau_pkg::CMD_DIV ||
            sts.cmd == mau_pkg::CMD_POW) begin
          ctl.op = mau_pkg::OP_PINIT;
          state_nxt = (sts.cmd == mau_pkg::CMD_MUL) ? S_FIN : S_PLOOP;
        end else begin
          ctl.op = mau_pkg::OP_SIMPLE; state_nxt = S_DONE;
        end
      end
      S_PLOOP: begin
        if (sts.exp_zero) begin
          state_nxt = S_FIN;
        end else if (sts.exp_lsb) begin
          ctl.op = mau_pkg::OP_MSTART_P; state_nxt = S_MULP;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_MULP: begin
        if (sts.mul_done) state_nxt = S_ENDP;
        else ctl.op = mau_pkg::OP_MSTEP;
      end
      S_ENDP: begin
        ctl.op = mau_pkg::OP_MEND_P; state_nxt = S_SQ;
      end
      S_SQ: begin
        ctl.op = mau_pkg::OP_MSTART_S; state_nxt = S_MULS;
      end
      S_MULS: begin
        if (sts.mul_done) state_nxt = S_ENDS;
        else ctl.op = mau_pkg::OP_MSTEP;
      end
      S_ENDS: begin
        ctl.op = mau_pkg::OP_MEND_S; state_nxt = S_PLOOP;
      end
      S_FIN: begin
        ctl.op = mau_pkg::OP_MSTART_F; state_nxt = S_MULF;
      end
      S_MULF: begin
        if (sts.mul_done) state_nxt = S_ENDF;
        else ctl.op = mau_pkg::OP_MSTEP;
      end
      S_ENDF: begin
        ctl.op = mau_pkg::OP_MEND_F; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          res_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      small_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      small_r <= small_nxt;
    end
  end

endmodule
